>>> rtl/core/vrt_pkg.sv
// Package: map geometry, field widths, codes and shared types of the voxel ray traversal core.
package vrt_pkg;

	localparam int MAP_X_BITS = 6;
	localparam int MAP_Y_BITS = 6;
	localparam int MAP_Z_SIZE = 64;
	localparam int Z_IDX_W = (MAP_Z_SIZE > 1) ? $clog2(MAP_Z_SIZE) : 1;
	localparam int IDX_W = MAP_X_BITS + MAP_Y_BITS + Z_IDX_W;
	localparam int WORD_W = 64;
	localparam int BIT_W = 6;
	localparam int MAP_BITS_TOTAL = (1 << (MAP_X_BITS + MAP_Y_BITS)) * MAP_Z_SIZE;
	localparam int MAP_WORDS = (MAP_BITS_TOTAL + WORD_W - 1) / WORD_W;
	localparam int WADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	localparam int OP_W = 2;
	localparam int S_W = 24;
	localparam int LEN_W = 16;
	localparam int HIT_W = 17;
	localparam int LIM_W = 8;
	localparam int E_W = 34;
	localparam int A_W = 27;
	localparam int F_W = 11;
	localparam int G_W = 37;
	localparam int M_W = F_W + G_W;
	localparam int P_W = 48;
	localparam int CNT_W = 28;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 8'd32;

	typedef enum logic [OP_W-1:0] {
		OP_LOS   = 2'd0,
		OP_RAY   = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_END,
		ST_AXIS,
		ST_PMUL,
		ST_WALK,
		ST_CHECK,
		ST_WR_RD,
		ST_WR_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic we;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic valid;
		logic blocked;
		logic signed [HIT_W-1:0] hit_x;
		logic signed [HIT_W-1:0] hit_y;
		logic signed [HIT_W-1:0] hit_z;
	} res_t;

endpackage

>>> rtl/core/vrt_item_if.sv
// Interface: input item channel of the voxel ray traversal core.
interface vrt_item_if;
	logic valid;
	logic ready;
	logic [vrt_pkg::OP_W-1:0] opcode;
	logic signed [vrt_pkg::S_W-1:0] start_x;
	logic signed [vrt_pkg::S_W-1:0] start_y;
	logic signed [vrt_pkg::S_W-1:0] start_z;
	logic signed [vrt_pkg::S_W-1:0] target_x;
	logic signed [vrt_pkg::S_W-1:0] target_y;
	logic signed [vrt_pkg::S_W-1:0] target_z;
	logic [vrt_pkg::LEN_W-1:0] ray_length;
	logic solid_bit;

	modport source (output valid, opcode, start_x, start_y, start_z, target_x, target_y,
		target_z, ray_length, solid_bit, input ready);
	modport sink (input valid, opcode, start_x, start_y, start_z, target_x, target_y,
		target_z, ray_length, solid_bit, output ready);
endinterface

>>> rtl/core/vrt_result_if.sv
// Interface: result channel of the voxel ray traversal core.
interface vrt_result_if;
	logic valid;
	logic ready;
	logic path_blocked;
	logic signed [vrt_pkg::HIT_W-1:0] hit_x;
	logic signed [vrt_pkg::HIT_W-1:0] hit_y;
	logic signed [vrt_pkg::HIT_W-1:0] hit_z;

	modport source (output valid, path_blocked, hit_x, hit_y, hit_z, input ready);
	modport sink (input valid, path_blocked, hit_x, hit_y, hit_z, output ready);
endinterface

>>> rtl/core/vrt_cfg_if.sv
// Interface: configuration write channel carrying the step limit register.
interface vrt_cfg_if;
	logic valid;
	logic ready;
	logic [vrt_pkg::LIM_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/voxel_ray_traversal_core.sv
// From accept to result word: a walk sets up end point, axes and decision terms, then per voxel
// step does a map read, then a check. A write reads the word, then writes it back, unless out of height.
// One item at a time; the step count is bounded by the step limit register or the ray length.
// Result leaves through an output register, so the next item is taken while it waits.
// Reset: step limit 32, then a clearing pass over all MAP_WORDS words (4096 at the default
// map) zeroes the map; items are held off meanwhile, configuration is taken as ever.
module voxel_ray_traversal_core (
	input  logic clk,
	input  logic arst_n,
	vrt_cfg_if.sink cfg,
	vrt_item_if.sink item_in,
	vrt_result_if.source result_out
);
	logic [vrt_pkg::LIM_W-1:0] step_limit_q;
	vrt_pkg::mem_req_t mem_req;
	logic [vrt_pkg::WORD_W-1:0] mem_rdata;
	vrt_pkg::res_t res;
	logic res_ack;
	logic out_valid_q;
	logic out_blocked_q;
	logic signed [vrt_pkg::HIT_W-1:0] out_x_q, out_y_q, out_z_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= vrt_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			step_limit_q <= cfg.data;
		end
	end

	vrt_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_in),
		.step_limit(step_limit_q),
		.mem_req(mem_req),
		.mem_rdata(mem_rdata),
		.res(res),
		.res_ack(res_ack)
	);

	vrt_ram #(
		.WIDTH(vrt_pkg::WORD_W),
		.DEPTH(vrt_pkg::MAP_WORDS)
	) u_map (
		.clk(clk),
		.en(mem_req.en),
		.we(mem_req.we),
		.addr(mem_req.addr),
		.wdata(mem_req.wdata),
		.rdata(mem_rdata)
	);

	// load a word when the output register is empty or being drained
	assign res_ack = !out_valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack && res.valid) begin
			out_blocked_q <= res.blocked;
			out_x_q <= res.hit_x;
			out_y_q <= res.hit_y;
			out_z_q <= res.hit_z;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.path_blocked = out_blocked_q;
	assign result_out.hit_x = out_x_q;
	assign result_out.hit_y = out_y_q;
	assign result_out.hit_z = out_z_q;
endmodule

>>> rtl/core/vrt_ram.sv
// Generic single-port synchronous RAM with registered read.
module vrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic clk,
	input  logic en,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule

>>> rtl/core/vrt_engine.sv
// Walk engine: setup arithmetic, DDA sequencer and map read-modify-write control.
module vrt_engine (
	input  logic clk,
	input  logic arst_n,
	vrt_item_if.sink item,
	input  logic [vrt_pkg::LIM_W-1:0] step_limit,
	output vrt_pkg::mem_req_t mem_req,
	input  logic [vrt_pkg::WORD_W-1:0] mem_rdata,
	output vrt_pkg::res_t res,
	input  logic res_ack
);
	vrt_pkg::state_t state_q, state_d;
	logic [vrt_pkg::WADDR_W-1:0] clr_q;
	logic [1:0] k_q;
	logic [2:0] j_q;

	logic [vrt_pkg::OP_W-1:0] op_q;
	logic signed [vrt_pkg::S_W-1:0] s_q [3];
	logic signed [vrt_pkg::S_W-1:0] t_q [3];
	logic [vrt_pkg::LEN_W-1:0] len_q;
	logic solid_q;
	logic signed [vrt_pkg::E_W-1:0] e_q [3];
	logic signed [vrt_pkg::A_W-1:0] a_q [3];
	logic signed [vrt_pkg::A_W-1:0] c_q [3];
	logic signed [1:0] d_q [3];
	logic signed [vrt_pkg::F_W-1:0] f_q [3];
	logic signed [vrt_pkg::G_W-1:0] g_q [3];
	logic signed [vrt_pkg::P_W-1:0] p_q [3];
	logic signed [vrt_pkg::M_W-1:0] prod_q;
	logic [vrt_pkg::CNT_W-1:0] cnt_sum_q;
	logic [vrt_pkg::LIM_W-1:0] cnt_q;
	logic [vrt_pkg::BIT_W-1:0] bit_q;
	logic blocked_q;
	logic signed [vrt_pkg::HIT_W-1:0] hit_q [3];

	function automatic logic signed [vrt_pkg::A_W-1:0] start_voxel(
		input logic signed [vrt_pkg::E_W-1:0] v);
		logic signed [vrt_pkg::E_W:0] x;
		x = (vrt_pkg::E_W+1)'(v) - (vrt_pkg::E_W+1)'(128);
		if (x < 0) begin
			x = x + (vrt_pkg::E_W+1)'(255);
		end
		return vrt_pkg::A_W'(x >>> 8);
	endfunction

	function automatic logic [vrt_pkg::WADDR_W-1:0] word_addr(input logic [vrt_pkg::IDX_W-1:0] i);
		return vrt_pkg::WADDR_W'(i >> vrt_pkg::BIT_W);
	endfunction

	// end point scaling
	logic signed [vrt_pkg::S_W+vrt_pkg::LEN_W:0] ray_prod;
	logic signed [vrt_pkg::S_W+vrt_pkg::LEN_W:0] ray_adj;
	logic signed [vrt_pkg::E_W-1:0] e_new;

	always_comb begin
		ray_prod = t_q[k_q] * $signed({1'b0, len_q});
		ray_adj = (ray_prod < 0) ? ray_prod + (vrt_pkg::S_W+vrt_pkg::LEN_W+1)'(255) : ray_prod;
		if (op_q == vrt_pkg::OP_RAY) begin
			e_new = vrt_pkg::E_W'(s_q[k_q]) + vrt_pkg::E_W'(ray_adj >>> 8);
		end else begin
			e_new = vrt_pkg::E_W'(t_q[k_q]);
		end
	end

	// per-axis setup
	logic signed [vrt_pkg::A_W-1:0] ax_a, ax_c;
	logic signed [vrt_pkg::A_W+8:0] ax_v0, ax_base;
	logic signed [vrt_pkg::G_W-1:0] ax_diff;
	logic signed [1:0] ax_d;
	logic signed [vrt_pkg::F_W-1:0] ax_f;
	logic signed [vrt_pkg::G_W-1:0] ax_g;
	logic [vrt_pkg::CNT_W-1:0] ax_dist;

	always_comb begin
		ax_a = start_voxel(vrt_pkg::E_W'(s_q[k_q]));
		ax_c = start_voxel(e_q[k_q]);
		ax_v0 = (vrt_pkg::A_W+9)'(s_q[k_q]);
		ax_base = (vrt_pkg::A_W+9)'(ax_a) <<< 8;
		ax_diff = vrt_pkg::G_W'(e_q[k_q]) - vrt_pkg::G_W'(s_q[k_q]);
		if (ax_c < ax_a) begin
			ax_d = -2'sd1;
			ax_f = vrt_pkg::F_W'(ax_v0 - ax_base);
			ax_g = -(ax_diff <<< 2);
			ax_dist = vrt_pkg::CNT_W'(ax_a - ax_c);
		end else if (ax_c != ax_a) begin
			ax_d = 2'sd1;
			ax_f = vrt_pkg::F_W'(ax_base + (vrt_pkg::A_W+9)'(256) - ax_v0);
			ax_g = ax_diff <<< 2;
			ax_dist = vrt_pkg::CNT_W'(ax_c - ax_a);
		end else begin
			ax_d = 2'sd0;
			ax_f = '0;
			ax_g = '0;
			ax_dist = '0;
		end
	end

	// decision term products: px = f0*g2 - f2*g0, py = f1*g2 - f2*g1, pz = f1*g0 - f0*g1
	logic signed [vrt_pkg::F_W-1:0] pm_f;
	logic signed [vrt_pkg::G_W-1:0] pm_g;
	logic signed [vrt_pkg::M_W-1:0] pm_prod;
	logic signed [vrt_pkg::M_W:0] pm_diff;
	logic signed [vrt_pkg::M_W:0] pm_adj;
	logic [vrt_pkg::LIM_W-1:0] lim;

	always_comb begin
		case (j_q)
			3'd0: begin pm_f = f_q[0]; pm_g = g_q[2]; end
			3'd1: begin pm_f = f_q[2]; pm_g = g_q[0]; end
			3'd2: begin pm_f = f_q[1]; pm_g = g_q[2]; end
			3'd3: begin pm_f = f_q[2]; pm_g = g_q[1]; end
			3'd4: begin pm_f = f_q[1]; pm_g = g_q[0]; end
			default: begin pm_f = f_q[0]; pm_g = g_q[1]; end
		endcase
		pm_prod = pm_f * pm_g;
		pm_diff = (vrt_pkg::M_W+1)'(prod_q) - (vrt_pkg::M_W+1)'(pm_prod);
		pm_adj = (pm_diff < 0) ? pm_diff + (vrt_pkg::M_W+1)'(255) : pm_diff;
		lim = (op_q == vrt_pkg::OP_LOS) ? step_limit : len_q[vrt_pkg::LEN_W-1:8];
	end

	// one DDA step
	logic signed [vrt_pkg::A_W-1:0] na [3];
	logic signed [vrt_pkg::P_W-1:0] np [3];
	logic [vrt_pkg::IDX_W-1:0] step_idx;
	logic [vrt_pkg::IDX_W-1:0] wr_idx;
	logic wr_in_range;
	logic chk_solid;

	always_comb begin
		na = a_q;
		np = p_q;
		if (p_q[0] >= 0 && p_q[1] >= 0 && a_q[2] != c_q[2]) begin
			na[2] = a_q[2] + vrt_pkg::A_W'(d_q[2]);
			np[0] = p_q[0] - vrt_pkg::P_W'(g_q[0]);
			np[1] = p_q[1] - vrt_pkg::P_W'(g_q[1]);
		end else if (p_q[2] >= 0 && a_q[0] != c_q[0]) begin
			na[0] = a_q[0] + vrt_pkg::A_W'(d_q[0]);
			np[0] = p_q[0] + vrt_pkg::P_W'(g_q[2]);
			np[2] = p_q[2] - vrt_pkg::P_W'(g_q[1]);
		end else begin
			na[1] = a_q[1] + vrt_pkg::A_W'(d_q[1]);
			np[1] = p_q[1] + vrt_pkg::P_W'(g_q[2]);
			np[2] = p_q[2] + vrt_pkg::P_W'(g_q[0]);
		end
		step_idx = {na[2][vrt_pkg::Z_IDX_W-1:0], na[1][vrt_pkg::MAP_Y_BITS-1:0],
			na[0][vrt_pkg::MAP_X_BITS-1:0]};
		wr_idx = {s_q[2][vrt_pkg::Z_IDX_W-1:0], s_q[1][vrt_pkg::MAP_Y_BITS-1:0],
			s_q[0][vrt_pkg::MAP_X_BITS-1:0]};
		wr_in_range = item.start_z >= 0 && item.start_z < vrt_pkg::S_W'(vrt_pkg::MAP_Z_SIZE);
		if (a_q[2] < 0) begin
			chk_solid = 1'b0;
		end else if (a_q[2] >= vrt_pkg::A_W'(vrt_pkg::MAP_Z_SIZE)) begin
			chk_solid = 1'b1;
		end else begin
			chk_solid = mem_rdata[bit_q];
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_req = '0;
		item.ready = 1'b0;
		unique case (state_q)
			vrt_pkg::ST_CLEAR: begin
				mem_req.en = 1'b1;
				mem_req.we = 1'b1;
				mem_req.addr = clr_q;
				if (clr_q == vrt_pkg::WADDR_W'(vrt_pkg::MAP_WORDS - 1)) begin
					state_d = vrt_pkg::ST_IDLE;
				end
			end
			vrt_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					unique case (item.opcode)
						vrt_pkg::OP_WRITE: begin
							state_d = wr_in_range ? vrt_pkg::ST_WR_RD : vrt_pkg::ST_DONE;
						end
						vrt_pkg::OP_LOS, vrt_pkg::OP_RAY: state_d = vrt_pkg::ST_END;
						default: state_d = vrt_pkg::ST_DONE;
					endcase
				end
			end
			vrt_pkg::ST_END: begin
				if (k_q == 2'd2) begin
					state_d = vrt_pkg::ST_AXIS;
				end
			end
			vrt_pkg::ST_AXIS: begin
				if (k_q == 2'd2) begin
					state_d = vrt_pkg::ST_PMUL;
				end
			end
			vrt_pkg::ST_PMUL: begin
				if (j_q == 3'd5) begin
					state_d = vrt_pkg::ST_WALK;
				end
			end
			vrt_pkg::ST_WALK: begin
				if (cnt_q == '0) begin
					state_d = vrt_pkg::ST_DONE;
				end else begin
					mem_req.en = 1'b1;
					mem_req.addr = word_addr(step_idx);
					state_d = vrt_pkg::ST_CHECK;
				end
			end
			vrt_pkg::ST_CHECK: begin
				if (chk_solid || cnt_q == vrt_pkg::LIM_W'(1)) begin
					state_d = vrt_pkg::ST_DONE;
				end else begin
					state_d = vrt_pkg::ST_WALK;
				end
			end
			vrt_pkg::ST_WR_RD: begin
				mem_req.en = 1'b1;
				mem_req.addr = word_addr(wr_idx);
				state_d = vrt_pkg::ST_WR_WB;
			end
			vrt_pkg::ST_WR_WB: begin
				mem_req.en = 1'b1;
				mem_req.we = 1'b1;
				mem_req.addr = word_addr(wr_idx);
				mem_req.wdata = mem_rdata;
				mem_req.wdata[wr_idx[vrt_pkg::BIT_W-1:0]] = solid_q;
				state_d = vrt_pkg::ST_DONE;
			end
			vrt_pkg::ST_DONE: begin
				if (res_ack) begin
					state_d = vrt_pkg::ST_IDLE;
				end
			end
			default: state_d = vrt_pkg::ST_CLEAR;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			k_q <= '0;
			j_q <= '0;
		end else begin
			if (state_q == vrt_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == vrt_pkg::ST_END || state_q == vrt_pkg::ST_AXIS) begin
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			if (state_q == vrt_pkg::ST_PMUL) begin
				j_q <= (j_q == 3'd5) ? 3'd0 : j_q + 3'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			vrt_pkg::ST_IDLE: begin
				if (item.valid) begin
					op_q <= item.opcode;
					s_q[0] <= item.start_x;
					s_q[1] <= item.start_y;
					s_q[2] <= item.start_z;
					t_q[0] <= item.target_x;
					t_q[1] <= item.target_y;
					t_q[2] <= item.target_z;
					len_q <= item.ray_length;
					solid_q <= item.solid_bit;
					cnt_sum_q <= '0;
					blocked_q <= 1'b0;
					hit_q[0] <= '0;
					hit_q[1] <= '0;
					hit_q[2] <= '0;
				end
			end
			vrt_pkg::ST_END: e_q[k_q] <= e_new;
			vrt_pkg::ST_AXIS: begin
				a_q[k_q] <= ax_a;
				c_q[k_q] <= ax_c;
				d_q[k_q] <= ax_d;
				f_q[k_q] <= ax_f;
				g_q[k_q] <= ax_g;
				cnt_sum_q <= cnt_sum_q + ax_dist;
			end
			vrt_pkg::ST_PMUL: begin
				if (!j_q[0]) begin
					prod_q <= pm_prod;
				end else begin
					p_q[j_q[2:1]] <= vrt_pkg::P_W'(pm_adj >>> 8);
				end
				if (j_q == 3'd5) begin
					cnt_q <= (cnt_sum_q > vrt_pkg::CNT_W'(lim)) ? lim
						: cnt_sum_q[vrt_pkg::LIM_W-1:0];
				end
			end
			vrt_pkg::ST_WALK: begin
				if (cnt_q != '0) begin
					a_q <= na;
					p_q <= np;
					bit_q <= step_idx[vrt_pkg::BIT_W-1:0];
				end
			end
			vrt_pkg::ST_CHECK: begin
				if (chk_solid) begin
					blocked_q <= 1'b1;
					hit_q[0] <= a_q[0][vrt_pkg::HIT_W-1:0];
					hit_q[1] <= a_q[1][vrt_pkg::HIT_W-1:0];
					hit_q[2] <= a_q[2][vrt_pkg::HIT_W-1:0];
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.valid = state_q == vrt_pkg::ST_DONE;
		res.blocked = blocked_q;
		res.hit_x = hit_q[0];
		res.hit_y = hit_q[1];
		res.hit_z = hit_q[2];
	end
endmodule
